/* rtl/pqg_pkg.sv */
// ----------------------------------------------------------------------------
// pqg_pkg
// Shared types and constants of the postfix quadruple generator.
// ----------------------------------------------------------------------------
package pqg_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned MaxTempsDef   = 64;

  localparam int unsigned SymW  = 8;
  localparam int unsigned OpndW = 10;
  localparam int unsigned KeyW  = SymW + 2 * OpndW;
  localparam int unsigned IdxW  = 8;

  localparam logic [1:0]      KindEmpty  = 2'd0;
  localparam logic [1:0]      KindLetter = 2'd1;
  localparam logic [1:0]      KindTemp   = 2'd2;
  localparam logic [SymW-1:0] AssignCode = 8'd61;

  typedef struct packed {
    logic            vld;
    logic            found;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } search_tok_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } table_wr_t;

  function automatic logic is_letter(input logic [SymW-1:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

/* rtl/postfix_quadruple_generator.sv */
// ----------------------------------------------------------------------------
// postfix_quadruple_generator
// Postfix to quadruple rows with reuse of common subexpressions.
// ----------------------------------------------------------------------------
// Input channel: symbol_i / end_of_expression_i, taken when in_valid_i is high
// and in_stall_o is low. Output channel: up to two rows per transaction, taken when
// out_valid_o is high and out_stall_i is low; last_row_o marks the final row
// of an input transaction.
// A letter is pushed on the operand stack; with the end mark it is followed by
// an assignment row. An operator pops two operands, then its key walks the
// chain of MAX_TEMPS table cells, one cell per cycle, then the search result is
// captured and the row is issued; the next transaction is taken after that, or
// after the assignment row when the operator carries the end mark.
// One transaction is worked on at a time; the next is taken once all its
// rows are in the output register.
// A stalled receiver holds the output row and the block waits before issuing
// the next row. Reset empties the operand stack and the table at once.
// ----------------------------------------------------------------------------
module postfix_quadruple_generator #(
  parameter int unsigned STACK_DEPTH = pqg_pkg::StackDepthDef,
  parameter int unsigned MAX_TEMPS   = pqg_pkg::MaxTempsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_expression_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] row_operator_o,
  output logic       is_assignment_o,
  output logic [1:0] first_arg_kind_o,
  output logic [7:0] first_arg_value_o,
  output logic [1:0] second_arg_kind_o,
  output logic [7:0] second_arg_value_o,
  output logic [6:0] result_temp_o,
  output logic       stack_fault_o,
  output logic       table_full_o,
  output logic       last_row_o
);

  localparam int unsigned SpW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW  = $clog2(STACK_DEPTH);
  localparam int unsigned TcW  = $clog2(MAX_TEMPS + 1);
  localparam int unsigned OW   = pqg_pkg::OpndW;
  localparam int unsigned IW   = pqg_pkg::IdxW;
  localparam logic [SpW-1:0] SpMax = SpW'(STACK_DEPTH);
  localparam logic [TcW-1:0] TcMax = TcW'(MAX_TEMPS);

  typedef enum logic [2:0] {
    StIdle,
    StPopR,
    StPopL,
    StSearch,
    StEmitOp,
    StEmitAsg
  } state_e;

  state_e               state_q;
  logic [SpW-1:0]       sp_q;
  logic [TcW-1:0]       tc_q;
  logic [OW-1:0]        stack_q [STACK_DEPTH];
  logic [7:0]           sym_q;
  logic                 end_q, pfault_q, sfault_q;
  logic [OW-1:0]        left_q, right_q;
  pqg_pkg::search_tok_t launch_q, res_tok, res_q;
  pqg_pkg::table_wr_t   twr;

  logic                 in_acc, out_free, emit_op, emit_asg;
  logic [OW-1:0]        top_val;
  logic                 sp_empty;
  logic [IW-1:0]        new_temp;
  logic [IW-1:0]        temp_fin;
  logic                 tfull;
  logic [OW-1:0]        pushed;
  logic                 push_en;
  logic [OW-1:0]        push_val;
  logic [SaW-1:0]       top_idx;

  logic [7:0]           row_op_q, a_val_q, b_val_q;
  logic [1:0]           a_kind_q, b_kind_q;
  logic [6:0]           rtemp_q;
  logic                 asg_q, rsf_q, rtf_q, last_q, ovld_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovld_q || !out_stall_i;
  assign emit_op    = (state_q == StEmitOp) && out_free;
  assign emit_asg   = (state_q == StEmitAsg) && out_free;

  assign sp_empty = (sp_q == '0);
  assign top_idx  = SaW'(sp_q - SpW'(1));
  assign top_val  = sp_empty ? '0 : stack_q[top_idx];

  assign new_temp = IW'(tc_q) + IW'(1);
  assign tfull    = !res_q.found && (tc_q >= TcMax);
  assign temp_fin = res_q.found ? res_q.idx : (tfull ? '0 : new_temp);
  assign pushed   = (temp_fin == '0) ? '0 : {pqg_pkg::KindTemp, temp_fin};

  assign twr.en  = emit_op && !res_q.found && !tfull;
  assign twr.idx = IW'(tc_q);
  assign twr.key = res_q.key;

  always_comb begin
    push_en  = 1'b0;
    push_val = pushed;
    if (in_acc && pqg_pkg::is_letter(symbol_i)) begin
      push_en  = 1'b1;
      push_val = {pqg_pkg::KindLetter, symbol_i};
    end else if (emit_op) begin
      push_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en && (sp_q < SpMax)) begin
      stack_q[SaW'(sp_q)] <= push_val;
    end
  end

  pqg_table #(
    .MaxTemps(MAX_TEMPS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (launch_q),
    .tok_o  (res_tok),
    .wr_i   (twr),
    .count_i(IW'(tc_q))
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      sp_q     <= '0;
      tc_q     <= '0;
      ovld_q   <= 1'b0;
      launch_q <= '0;
      res_q    <= '0;
      sym_q    <= '0;
      end_q    <= 1'b0;
      pfault_q <= 1'b0;
      sfault_q <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      row_op_q <= '0;
      asg_q    <= 1'b0;
      a_kind_q <= '0;
      a_val_q  <= '0;
      b_kind_q <= '0;
      b_val_q  <= '0;
      rtemp_q  <= '0;
      rsf_q    <= 1'b0;
      rtf_q    <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      launch_q.vld <= (state_q == StPopL);
      if (emit_op || emit_asg) begin
        ovld_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            sym_q    <= symbol_i;
            end_q    <= end_of_expression_i;
            pfault_q <= 1'b0;
            sfault_q <= 1'b0;
            if (pqg_pkg::is_letter(symbol_i)) begin
              if (sp_q < SpMax) begin
                sp_q <= sp_q + SpW'(1);
              end else begin
                pfault_q <= 1'b1;
              end
              if (end_of_expression_i) begin
                state_q <= StEmitAsg;
              end
            end else begin
              state_q <= StPopR;
            end
          end
        end
        StPopR: begin
          right_q <= top_val;
          if (sp_empty) begin
            sfault_q <= 1'b1;
          end else begin
            sp_q <= sp_q - SpW'(1);
          end
          state_q <= StPopL;
        end
        StPopL: begin
          left_q <= top_val;
          if (sp_empty) begin
            sfault_q <= 1'b1;
          end else begin
            sp_q <= sp_q - SpW'(1);
          end
          launch_q.found <= 1'b0;
          launch_q.idx   <= '0;
          launch_q.key   <= {sym_q, top_val, right_q};
          state_q        <= StSearch;
        end
        StSearch: begin
          if (res_tok.vld) begin
            res_q   <= res_tok;
            state_q <= StEmitOp;
          end
        end
        StEmitOp: begin
          if (out_free) begin
            row_op_q <= sym_q;
            asg_q    <= 1'b0;
            a_kind_q <= left_q[OW-1:8];
            a_val_q  <= left_q[7:0];
            b_kind_q <= right_q[OW-1:8];
            b_val_q  <= right_q[7:0];
            rtemp_q  <= temp_fin[6:0];
            rsf_q    <= sfault_q || (sp_q >= SpMax);
            rtf_q    <= tfull;
            last_q   <= !end_q;
            if (twr.en) begin
              tc_q <= tc_q + TcW'(1);
            end
            if (sp_q < SpMax) begin
              sp_q <= sp_q + SpW'(1);
            end
            state_q <= end_q ? StEmitAsg : StIdle;
          end
        end
        StEmitAsg: begin
          if (out_free) begin
            row_op_q <= pqg_pkg::AssignCode;
            asg_q    <= 1'b1;
            a_kind_q <= top_val[OW-1:8];
            a_val_q  <= top_val[7:0];
            b_kind_q <= pqg_pkg::KindEmpty;
            b_val_q  <= '0;
            rtemp_q  <= '0;
            rsf_q    <= pfault_q || sp_empty;
            rtf_q    <= 1'b0;
            last_q   <= 1'b1;
            sp_q     <= '0;
            tc_q     <= '0;
            state_q  <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o        = ovld_q;
  assign row_operator_o     = row_op_q;
  assign is_assignment_o    = asg_q;
  assign first_arg_kind_o   = a_kind_q;
  assign first_arg_value_o  = a_val_q;
  assign second_arg_kind_o  = b_kind_q;
  assign second_arg_value_o = b_val_q;
  assign result_temp_o      = rtemp_q;
  assign stack_fault_o      = rsf_q;
  assign table_full_o       = rtf_q;
  assign last_row_o         = last_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SpMax)
    else $error("stack pointer beyond depth");
  a_tc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) tc_q <= TcMax)
    else $error("temporary count beyond table size");
  a_res_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_tok.vld |-> (state_q == StSearch))
    else $error("search result outside search");
  a_asg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_asg |=> (sp_q == '0) && (tc_q == '0))
    else $error("state not cleared after assignment row");

endmodule

/* rtl/pqg_cell.sv */
// ----------------------------------------------------------------------------
// pqg_cell
// One temporary table entry; compares the passing search token with its key.
// ----------------------------------------------------------------------------
module pqg_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pqg_pkg::search_tok_t          tok_i,
  output pqg_pkg::search_tok_t          tok_o,
  input  pqg_pkg::table_wr_t            wr_i,
  input  logic [pqg_pkg::IdxW-1:0]      count_i
);

  localparam logic [pqg_pkg::IdxW-1:0] MyIdx  = pqg_pkg::IdxW'(CellIdx);
  localparam logic [pqg_pkg::IdxW-1:0] MyTemp = pqg_pkg::IdxW'(CellIdx + 1);

  logic [pqg_pkg::KeyW-1:0] entry_q;
  pqg_pkg::search_tok_t     tok_q, tok_d;
  logic                     hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == MyIdx)) begin
      entry_q <= wr_i.key;
    end
  end

  assign hit = tok_i.vld && !tok_i.found && (MyIdx < count_i) && (entry_q == tok_i.key);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.idx   = MyTemp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/pqg_table.sv */
// ----------------------------------------------------------------------------
// pqg_table
// Chain of table cells; the search token advances one cell per cycle.
// ----------------------------------------------------------------------------
module pqg_table #(
  parameter int unsigned MaxTemps = pqg_pkg::MaxTempsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pqg_pkg::search_tok_t     tok_i,
  output pqg_pkg::search_tok_t     tok_o,
  input  pqg_pkg::table_wr_t       wr_i,
  input  logic [pqg_pkg::IdxW-1:0] count_i
);

  pqg_pkg::search_tok_t chain [MaxTemps+1];

  assign chain[0] = tok_i;

  for (genvar g = 0; g < MaxTemps; g++) begin : g_cell
    pqg_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1]),
      .wr_i   (wr_i),
      .count_i(count_i)
    );
  end

  assign tok_o = chain[MaxTemps];

endmodule

/* sim/tb_postfix_quadruple_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_postfix_quadruple_generator
// Drives postfix symbols into the generator, predicts the quadruple and
// assignment rows with a behavioural model of stack and temporary table, and
// compares every row field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_postfix_quadruple_generator;

  localparam int unsigned Depth   = pqg_pkg::StackDepthDef;
  localparam int unsigned Temps   = pqg_pkg::MaxTempsDef;
  localparam int unsigned IdleMax = 20000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] val;
  } opnd_t;

  typedef struct packed {
    logic [7:0] op;
    logic       assign_row;
    opnd_t      first;
    opnd_t      second;
    logic [6:0] temp;
    logic       sfault;
    logic       tfull;
    logic       last;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] symbol_i;
  logic       end_of_expression_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] row_operator_o;
  logic       is_assignment_o;
  logic [1:0] first_arg_kind_o;
  logic [7:0] first_arg_value_o;
  logic [1:0] second_arg_kind_o;
  logic [7:0] second_arg_value_o;
  logic [6:0] result_temp_o;
  logic       stack_fault_o;
  logic       table_full_o;
  logic       last_row_o;

  opnd_t                    opnd_stack [Depth];
  int unsigned              stack_top;
  logic [pqg_pkg::KeyW-1:0] tuple_table [Temps];
  int unsigned              tuple_count;
  row_t                     expected_rows [$];
  int unsigned              error_count;
  int unsigned              idle_cycles;
  bit                       sent_now;

  postfix_quadruple_generator dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic letter_code(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 120);
  endfunction

  task automatic predict_rows(input logic [7:0] sym, input logic eoe);
    row_t  r;
    opnd_t lhs, rhs, pushed, top;
    logic  sfault, tfull, push_fault;
    logic [pqg_pkg::KeyW-1:0] key;
    int unsigned temp;
    push_fault = 1'b0;
    if (letter_code(sym)) begin
      if (stack_top < Depth) begin
        opnd_stack[stack_top] = {pqg_pkg::KindLetter, sym};
        stack_top++;
      end else begin
        push_fault = 1'b1;
      end
    end else begin
      sfault = 1'b0;
      tfull  = 1'b0;
      rhs = '0;
      lhs = '0;
      if (stack_top == 0) sfault = 1'b1;
      else begin
        stack_top--;
        rhs = opnd_stack[stack_top];
      end
      if (stack_top == 0) sfault = 1'b1;
      else begin
        stack_top--;
        lhs = opnd_stack[stack_top];
      end
      key  = {sym, lhs, rhs};
      temp = 0;
      for (int i = 0; i < tuple_count; i++) begin
        if (temp == 0 && tuple_table[i] == key) temp = i + 1;
      end
      if (temp == 0) begin
        if (tuple_count < Temps) begin
          tuple_table[tuple_count] = key;
          tuple_count++;
          temp = tuple_count;
        end else begin
          tfull = 1'b1;
        end
      end
      pushed = (temp != 0) ? {pqg_pkg::KindTemp, 8'(temp)} : '0;
      if (stack_top < Depth) begin
        opnd_stack[stack_top] = pushed;
        stack_top++;
      end else begin
        sfault = 1'b1;
      end
      r = '{sym, 1'b0, lhs, rhs, 7'(temp), sfault, tfull, !eoe};
      expected_rows.push_back(r);
    end
    if (eoe) begin
      top = '0;
      sfault = push_fault;
      if (stack_top == 0) sfault = 1'b1;
      else top = opnd_stack[stack_top-1];
      r = '{pqg_pkg::AssignCode, 1'b1, top, opnd_t'('0), 7'd0, sfault, 1'b0, 1'b1};
      expected_rows.push_back(r);
      stack_top   = 0;
      tuple_count = 0;
    end
  endtask

  // valid stays high on return; the next call drops it or drives the next symbol, drain_rows drops it
  task automatic send_symbol(input logic [7:0] sym, input logic eoe);
    int unsigned gap;
    gap = gap_length();
    if (gap > 60) gap = $urandom_range(4, 60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    symbol_i            <= sym;
    end_of_expression_i <= eoe;
    do @(posedge clk_i); while (in_stall_o);
    predict_rows(sym, eoe);
    @(negedge clk_i);
  endtask

  task automatic drain_rows();
    in_valid_i <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk_i);
    repeat (Temps + 10) @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) : 8'($urandom_range("a", "z"));
  endfunction

  function automatic logic [7:0] random_operator();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (letter_code(c));
    return c;
  endfunction

  // extremes, empty pops, overflow, reuse
  task automatic test_directed();
    send_symbol("a", 1'b0);
    send_symbol("b", 1'b0);
    send_symbol("+", 1'b0);
    send_symbol("a", 1'b0);
    send_symbol("b", 1'b0);
    send_symbol("+", 1'b0);
    send_symbol("*", 1'b1);
    send_symbol("Z", 1'b1);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b1);
    send_symbol("z", 1'b0);
    send_symbol("A", 1'b1);
    send_symbol("-", 1'b1);
    drain_rows();
    for (int i = 0; i < Depth + 2; i++) send_symbol(random_letter(), 1'b0);
    send_symbol("q", 1'b1);
    drain_rows();
  endtask

  task automatic test_table_full();
    send_symbol("a", 1'b0);
    for (int i = 0; i < Temps + 3; i++) begin
      send_symbol(8'(i), 1'b0);
      send_symbol(random_letter(), 1'b0);
    end
    send_symbol("/", 1'b1);
    drain_rows();
  endtask

  task automatic test_random_expressions(input int unsigned n_items);
    int unsigned sent, depth, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        depth = 0;
        len   = $urandom_range(1, 20);
        for (int k = 0; k < len; k++) begin
          if (depth < 2 || ($urandom_range(0, 1) && depth < Depth - 1)) begin
            send_symbol($urandom_range(0, 3) ? random_letter() : 8'("a" + $urandom_range(0, 2)),
                        1'b0);
            depth++;
          end else begin
            send_symbol($urandom_range(0, 1) ? 8'("+") : random_operator(), 1'b0);
            depth--;
          end
          sent++;
        end
        send_symbol(depth > 1 ? random_operator() : random_letter(), 1'b1);
      end else begin
        send_symbol(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
      end
      sent++;
      if (sent > n_items / 2 && sent < n_items / 2 + 25) drain_rows();
    end
    send_symbol("x", 1'b1);
    drain_rows();
  endtask

  // stall generator and row checker
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= (gap_length() != 0);
  end

  always @(posedge clk_i) begin
    row_t exp_row;
    sent_now = in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rows.size() == 0) begin
        $error("row with nothing expected: operator %0d", row_operator_o);
        error_count++;
      end else begin
        exp_row = expected_rows.pop_front();
        if (row_operator_o !== exp_row.op) begin
          $error("row_operator exp %0d got %0d", exp_row.op, row_operator_o); error_count++;
        end
        if (is_assignment_o !== exp_row.assign_row) begin
          $error("is_assignment exp %0d got %0d", exp_row.assign_row, is_assignment_o);
          error_count++;
        end
        if (first_arg_kind_o !== exp_row.first.kind) begin
          $error("first_arg_kind exp %0d got %0d", exp_row.first.kind, first_arg_kind_o);
          error_count++;
        end
        if (first_arg_value_o !== exp_row.first.val) begin
          $error("first_arg_value exp %0d got %0d", exp_row.first.val, first_arg_value_o);
          error_count++;
        end
        if (second_arg_kind_o !== exp_row.second.kind) begin
          $error("second_arg_kind exp %0d got %0d", exp_row.second.kind, second_arg_kind_o);
          error_count++;
        end
        if (second_arg_value_o !== exp_row.second.val) begin
          $error("second_arg_value exp %0d got %0d", exp_row.second.val, second_arg_value_o);
          error_count++;
        end
        if (result_temp_o !== exp_row.temp) begin
          $error("result_temp exp %0d got %0d", exp_row.temp, result_temp_o); error_count++;
        end
        if (stack_fault_o !== exp_row.sfault) begin
          $error("stack_fault exp %0d got %0d", exp_row.sfault, stack_fault_o); error_count++;
        end
        if (table_full_o !== exp_row.tfull) begin
          $error("table_full exp %0d got %0d", exp_row.tfull, table_full_o); error_count++;
        end
        if (last_row_o !== exp_row.last) begin
          $error("last_row exp %0d got %0d", exp_row.last, last_row_o); error_count++;
        end
      end
      idle_cycles = 0;
    end else if (sent_now) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleMax) begin
        $display("tb_postfix_quadruple_generator: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    symbol_i            = '0;
    end_of_expression_i = 1'b0;
    out_stall_i         = 1'b0;
    stack_top           = 0;
    tuple_count         = 0;
    error_count         = 0;
    idle_cycles         = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_table_full();
    test_random_expressions(680);
    if (error_count == 0) begin
      $display("tb_postfix_quadruple_generator: clean");
    end else begin
      $display("tb_postfix_quadruple_generator: errors");
    end
    $finish;
  end

endmodule
